// ----- design/qpft_pkg.sv -----
// Shared types, widths, request codes and width helpers for the queue position fill tracker.
package qpft_pkg;

	localparam int PRICE_BITS = 32;
	localparam int QTY_BITS   = 32;
	localparam int PORT_BITS  = 32;
	localparam int TIME_BITS  = 63;
	localparam int CNT_BITS   = 32;

	typedef logic [PRICE_BITS-1:0] price_t;
	typedef logic [QTY_BITS-1:0]   qty_t;
	typedef logic [PORT_BITS-1:0]  port_word_t;
	typedef logic [TIME_BITS-1:0]  time_t;
	typedef logic [CNT_BITS-1:0]   cnt_t;

	typedef enum logic [1:0] {
		REQ_PLACE  = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_TRADE  = 2'd2,
		REQ_NONE   = 2'd3
	} req_t;

	localparam logic SIDE_BUY  = 1'b0;
	localparam logic SIDE_SELL = 1'b1;

	// Port word to internal price, zero extended or truncated
	function automatic price_t to_price(input port_word_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[PRICE_BITS-1:0];
	endfunction

	function automatic qty_t to_qty(input port_word_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[QTY_BITS-1:0];
	endfunction

	function automatic port_word_t price_to_port(input price_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[PORT_BITS-1:0];
	endfunction

	function automatic port_word_t qty_to_port(input qty_t v);
		logic [63:0] w;
		w = 64'(v);
		return w[PORT_BITS-1:0];
	endfunction

endpackage

// ----- design/queue_position_fill_tracker.sv -----
// An accepted transaction is registered in the input register, then resolved against the
// order state; a resulting fill is registered in the fill register.
// Throughput: one transaction per cycle while the output is not stalled; the single
// compare/subtract/min pass between the input register and the fill register sets this.
// Reset: arst_n clears both orders, the fill counter and all valid flags.
module queue_position_fill_tracker (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_stall,
	input  logic [1:0]               req_type,
	input  logic                     side,
	input  qpft_pkg::port_word_t     price,
	input  qpft_pkg::port_word_t     amount,
	input  qpft_pkg::time_t          timestamp,
	input  qpft_pkg::port_word_t     queue_ahead_in,
	output logic                     out_valid,
	input  logic                     out_stall,
	output logic                     fill_side,
	output qpft_pkg::port_word_t     fill_price,
	output qpft_pkg::port_word_t     fill_amount,
	output qpft_pkg::time_t          fill_time,
	output qpft_pkg::port_word_t     fill_total
);

	// Input register
	logic                  valid_s1;
	logic [1:0]            req_s1;
	logic                  side_s1;
	qpft_pkg::price_t      price_s1;
	qpft_pkg::qty_t        amount_s1;
	qpft_pkg::time_t       time_s1;
	qpft_pkg::qty_t        qin_s1;

	// Order state, index 0 bid, 1 ask
	logic                  live_q  [2];
	qpft_pkg::price_t      price_q [2];
	qpft_pkg::qty_t        left_q  [2];
	qpft_pkg::qty_t        queue_q [2];
	qpft_pkg::cnt_t        cnt_q;

	// Output register
	logic                  out_valid_q;
	logic                  fill_side_q;
	qpft_pkg::price_t      fill_price_q;
	qpft_pkg::qty_t        fill_amount_q;
	qpft_pkg::time_t       fill_time_q;
	qpft_pkg::cnt_t        fill_total_q;

	logic                  out_free;
	logic                  advance;
	logic                  in_take;

	// Next-state values from the resolve pass
	logic                  nxt_live  [2];
	qpft_pkg::price_t      nxt_price [2];
	qpft_pkg::qty_t        nxt_left  [2];
	qpft_pkg::qty_t        nxt_queue [2];
	logic                  fire;
	logic                  tgt;
	logic                  crosses;
	qpft_pkg::qty_t        used;
	qpft_pkg::qty_t        rest;
	qpft_pkg::qty_t        qty;
	qpft_pkg::qty_t        left_after;

	// Handshake: the s1 item moves on whenever the fill register can take a result
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1    <= req_type;
			side_s1   <= side;
			price_s1  <= qpft_pkg::to_price(price);
			amount_s1 <= qpft_pkg::to_qty(amount);
			time_s1   <= timestamp;
			qin_s1    <= qpft_pkg::to_qty(queue_ahead_in);
		end
	end

	// Resolve one transaction against the stored orders
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			nxt_live[i]  = live_q[i];
			nxt_price[i] = price_q[i];
			nxt_left[i]  = left_q[i];
			nxt_queue[i] = queue_q[i];
		end
		fire       = 1'b0;
		// sell aggressor hits the bid, buy aggressor hits the ask
		tgt        = (side_s1 == qpft_pkg::SIDE_SELL) ? 1'b0 : 1'b1;
		crosses    = (tgt == 1'b0) ? (price_s1 <= price_q[tgt]) : (price_s1 >= price_q[tgt]);
		used       = (amount_s1 < queue_q[tgt]) ? amount_s1 : queue_q[tgt];
		rest       = amount_s1 - used;
		qty        = (left_q[tgt] < rest) ? left_q[tgt] : rest;
		left_after = left_q[tgt] - qty;

		case (req_s1)
			qpft_pkg::REQ_PLACE: begin
				if (amount_s1 == '0) begin
					nxt_live[side_s1]  = 1'b0;
					nxt_left[side_s1]  = '0;
					nxt_queue[side_s1] = '0;
				end else if (live_q[side_s1] && price_q[side_s1] == price_s1) begin
					// same price: resize only, queue place kept
					nxt_left[side_s1] = amount_s1;
				end else begin
					nxt_live[side_s1]  = 1'b1;
					nxt_price[side_s1] = price_s1;
					nxt_left[side_s1]  = amount_s1;
					nxt_queue[side_s1] = qin_s1;
				end
			end
			qpft_pkg::REQ_CANCEL: begin
				nxt_live[side_s1]  = 1'b0;
				nxt_left[side_s1]  = '0;
				nxt_queue[side_s1] = '0;
			end
			qpft_pkg::REQ_TRADE: begin
				if (live_q[tgt] && left_q[tgt] != '0 && crosses) begin
					nxt_queue[tgt] = queue_q[tgt] - used;
					if (rest != '0) begin
						fire          = 1'b1;
						nxt_left[tgt] = left_after;
						if (left_after == '0) begin
							nxt_live[tgt]  = 1'b0;
							nxt_queue[tgt] = '0;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	// Order state and fill counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 2; i++) begin
				live_q[i]  <= 1'b0;
				price_q[i] <= '0;
				left_q[i]  <= '0;
				queue_q[i] <= '0;
			end
			cnt_q <= '0;
		end else if (advance) begin
			for (int i = 0; i < 2; i++) begin
				live_q[i]  <= nxt_live[i];
				price_q[i] <= nxt_price[i];
				left_q[i]  <= nxt_left[i];
				queue_q[i] <= nxt_queue[i];
			end
			if (fire) begin
				cnt_q <= cnt_q + qpft_pkg::cnt_t'(1);
			end
		end
	end

	// Fill register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && fire;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && fire) begin
			fill_side_q   <= tgt;
			fill_price_q  <= price_q[tgt];
			fill_amount_q <= qty;
			fill_time_q   <= time_s1;
			fill_total_q  <= cnt_q + qpft_pkg::cnt_t'(1);
		end
	end

	assign out_valid   = out_valid_q;
	assign fill_side   = fill_side_q;
	assign fill_price  = qpft_pkg::price_to_port(fill_price_q);
	assign fill_amount = qpft_pkg::qty_to_port(fill_amount_q);
	assign fill_time   = fill_time_q;
	assign fill_total  = qpft_pkg::port_word_t'(fill_total_q);

endmodule

// ----- design/qpft_checker.sv -----
// Port-level checker for the queue position fill tracker, bound to the top level.
module qpft_checker (
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_stall,
	input logic                 out_valid,
	input logic                 out_stall,
	input logic                 fill_side,
	input qpft_pkg::port_word_t fill_price,
	input qpft_pkg::port_word_t fill_amount,
	input qpft_pkg::time_t      fill_time,
	input qpft_pkg::port_word_t fill_total
);

	// A stalled fill holds its transaction
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(fill_side) && $stable(fill_price)
			&& $stable(fill_amount) && $stable(fill_time) && $stable(fill_total))
		else $error("stalled fill changed");

	// A fill always carries lots
	a_fill_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> fill_amount != '0)
		else $error("fill with zero amount");

	// Back-to-back fills count up by one
	a_total_step: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_stall) ##1 out_valid |-> fill_total == $past(fill_total) + 32'd1)
		else $error("fill count skipped");

	// The input side stalls only while the output side is stalled
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without output backpressure");

endmodule

bind queue_position_fill_tracker qpft_checker u_qpft_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_stall    (in_stall),
	.out_valid   (out_valid),
	.out_stall   (out_stall),
	.fill_side   (fill_side),
	.fill_price  (fill_price),
	.fill_amount (fill_amount),
	.fill_time   (fill_time),
	.fill_total  (fill_total)
);
